// ===== sv/pwr_pkg.sv =====
// Package for the path waypoint resampler: constants, field widths and the
// segment descriptor passed from the front end to the back end. No dependencies.
`default_nettype none
package pwr_pkg;
	localparam int MaxSamples = 64;
	localparam int CntW = $clog2(MaxSamples + 2);
	localparam int QDepth = 2;
	localparam logic [15:0] StepReset = 16'd128;

	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [15:0] hd;
		logic signed [15:0] sp;
		logic signed [15:0] st;
		logic [51:0] at;
		logic [31:0] ix;
		logic [31:0] iy;
		logic [51:0] it;
		logic [CntW-1:0] n;
		logic clip;
	} seg_t;
endpackage
`default_nettype wire

// ===== sv/pwr_div.sv =====
// Iterative restoring divider: rounded quotient of a signed dividend by a
// small count, ties away from zero. Uses pwr_pkg.
`default_nettype none
module pwr_div import pwr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [52:0] num,
	input wire logic [CntW-1:0] den,
	output logic busy,
	output logic [52:0] quo
);
	// Divide (2|num| + n) by 2n; 55-bit dividend, one bit a cycle.
	localparam int DW = 55;
	logic [DW-1:0] dvd_q;
	logic [DW-1:0] q_q;
	logic [CntW+1:0] rem_q;
	logic [CntW:0] dd_q;
	logic neg_q;
	logic [5:0] cnt_q;
	logic [CntW+1:0] trial;
	logic [52:0] mag;
	logic [53:0] mq;

	assign mag = num[52] ? 53'(-num) : 53'(num);
	assign trial = {rem_q[CntW:0], dvd_q[DW-1]};
	assign mq = neg_q ? 54'(-{1'b0, q_q[52:0]}) : {1'b0, q_q[52:0]};
	assign quo = mq[52:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy <= 1'b1;
			cnt_q <= 6'(DW);
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {1'b0, mag, 1'b0} + DW'(den);
			dd_q <= {den, 1'b0};
			rem_q <= '0;
			q_q <= '0;
			neg_q <= num[52];
		end else if (busy) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			if (trial >= {1'b0, dd_q}) begin
				rem_q <= trial - {1'b0, dd_q};
				q_q <= {q_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q <= {q_q[DW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/pwr_front.sv =====
// Front end: keeps the previous waypoint, counts samples for each segment by
// stepwise squared compares and computes the three increments. Uses pwr_pkg, pwr_div.
`default_nettype none
module pwr_front import pwr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [15:0] step_q,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [31:0] px,
	input wire logic signed [31:0] py,
	input wire logic signed [15:0] phd,
	input wire logic signed [15:0] psp,
	input wire logic signed [15:0] pst,
	input wire logic [51:0] pt,
	output logic seg_valid,
	output seg_t seg,
	input wire logic seg_full
);
	localparam logic [2:0] S_IDLE = 3'd0, S_SQ = 3'd1, S_CNT = 3'd2,
		S_DIV = 3'd3, S_WAIT = 3'd4, S_PUSH = 3'd5;
	logic [2:0] state_q;
	logic have_q;
	logic signed [31:0] ax_q, ay_q;
	logic signed [15:0] hd_q, sp_q, st_q;
	logic [51:0] at_q;
	logic signed [32:0] dx_q, dy_q;
	logic signed [52:0] dt_q;
	logic [31:0] mx_q, my_q;
	logic [63:0] sq_q;
	logic [63:0] s_q;
	logic [CntW-1:0] n_q;
	logic [16:0] step1;
	logic [31:0] d_q;
	logic [63:0] dsq;
	logic [1:0] dsel_q;
	logic [52:0] qx_q, qy_q;
	logic dstart;
	logic dbusy;
	logic [52:0] dquo;
	logic signed [52:0] dnum;
	logic [63:0] msq;
	logic [31:0] msel;
	logic big;
	logic accept;

	assign step1 = (step_q == 16'd0) ? 17'd1 : {1'b0, step_q};
	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign msel = (dsel_q == 2'd2) ? my_q : mx_q;
	assign msq = msel * msel;
	assign dsq = d_q * d_q;
	assign dnum = (dsel_q == 2'd0) ? 53'(dx_q) : (dsel_q == 2'd1) ? 53'(dy_q) : dt_q;
	assign dstart = (state_q == S_DIV);
	// A distance of 2^31 or more is always capped.
	assign big = mx_q[31] || my_q[31];

	pwr_div u_div (.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum),
		.den(n_q), .busy(dbusy), .quo(dquo));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			have_q <= 1'b0;
			ax_q <= '0; ay_q <= '0; hd_q <= '0; sp_q <= '0; st_q <= '0; at_q <= '0;
			seg_valid <= 1'b0;
			dsel_q <= '0;
		end else begin
			seg_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						have_q <= 1'b1;
						ax_q <= px; ay_q <= py; hd_q <= phd; sp_q <= psp; st_q <= pst;
						at_q <= pt;
						if (have_q) state_q <= S_SQ;
					end
				end
				S_SQ: begin
					dsel_q <= dsel_q + 2'd1;
					if (dsel_q == 2'd2) begin
						dsel_q <= '0;
						state_q <= S_CNT;
					end
				end
				S_CNT: begin
					if (big || n_q > CntW'(MaxSamples)) begin
						state_q <= S_DIV;
					end else if (dsq > s_q) begin
						state_q <= (n_q == '0) ? S_IDLE : S_DIV;
					end
				end
				S_DIV: state_q <= S_WAIT;
				S_WAIT: begin
					if (!dbusy) begin
						if (dsel_q == 2'd2) begin
							state_q <= S_PUSH;
						end else begin
							dsel_q <= dsel_q + 2'd1;
							state_q <= S_DIV;
						end
					end
				end
				S_PUSH: begin
					if (!seg_full) begin
						seg_valid <= 1'b1;
						dsel_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dx_q <= 33'(px) - 33'(ax_q);
			dy_q <= 33'(py) - 33'(ay_q);
			dt_q <= 53'(pt) - 53'(at_q);
			seg.ax <= ax_q; seg.ay <= ay_q; seg.hd <= hd_q; seg.sp <= sp_q;
			seg.st <= st_q; seg.at <= at_q;
		end
		if (state_q == S_IDLE) begin
			s_q <= '0;
		end
		if (state_q == S_SQ) begin
			// Magnitudes are loaded in the first pass and squared one per pass after.
			if (dsel_q == 2'd0) begin
				mx_q <= dx_q[32] ? 32'(-dx_q) : 32'(dx_q);
				my_q <= dy_q[32] ? 32'(-dy_q) : 32'(dy_q);
			end else if (dsel_q == 2'd1) begin
				sq_q <= msq;
			end else begin
				s_q <= sq_q + msq;
			end
			n_q <= '0;
			d_q <= 32'(step1);
		end
		if (state_q == S_CNT) begin
			if (big) begin
				n_q <= CntW'(MaxSamples);
				seg.clip <= 1'b1;
			end else if (n_q > CntW'(MaxSamples)) begin
				n_q <= CntW'(MaxSamples);
				seg.clip <= 1'b1;
			end else if (dsq > s_q) begin
				seg.clip <= 1'b0;
			end else begin
				n_q <= n_q + 1'b1;
				d_q <= d_q + 32'(step1);
			end
		end
		if (state_q == S_WAIT && !dbusy) begin
			unique case (dsel_q)
				2'd0: qx_q <= dquo;
				2'd1: qy_q <= dquo;
				default: seg.it <= dquo[51:0];
			endcase
		end
		if (state_q == S_PUSH) begin
			seg.ix <= qx_q[31:0];
			seg.iy <= qy_q[31:0];
			seg.n <= n_q;
		end
	end
endmodule
`default_nettype wire

// ===== sv/pwr_back.sv =====
// Back end: a two-entry segment queue and the sample emitter with its output
// register. Uses pwr_pkg.
`default_nettype none
module pwr_back import pwr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic seg_valid,
	input wire seg_t seg,
	output logic seg_full,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [15:0] out_heading,
	output logic signed [15:0] out_speed,
	output logic signed [15:0] out_steer,
	output logic [51:0] out_time_us,
	output logic last_of_segment,
	output logic clipped
);
	seg_t fifo_q [QDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic act_q;
	seg_t cur_q;
	logic [CntW-1:0] k_q;
	logic [31:0] rx_q, ry_q;
	logic [51:0] rt_q;
	logic pop, emit;

	assign seg_full = (cnt_q == 2'(QDepth));
	assign pop = !act_q && cnt_q != 2'd0;
	assign emit = act_q && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0; act_q <= 1'b0; out_valid <= 1'b0;
		end else begin
			if (seg_valid) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, seg_valid} - {1'b0, pop};
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (pop) act_q <= 1'b1;
			if (emit) begin
				out_valid <= 1'b1;
				if (k_q + 1'b1 == cur_q.n) act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seg_valid) fifo_q[wp_q] <= seg;
		if (pop) begin
			cur_q <= fifo_q[rp_q];
			k_q <= '0;
			rx_q <= fifo_q[rp_q].ax;
			ry_q <= fifo_q[rp_q].ay;
			rt_q <= fifo_q[rp_q].at;
		end
		if (emit) begin
			out_x <= rx_q; out_y <= ry_q; out_time_us <= rt_q;
			out_heading <= cur_q.hd; out_speed <= cur_q.sp; out_steer <= cur_q.st;
			last_of_segment <= (k_q + 1'b1 == cur_q.n);
			clipped <= cur_q.clip;
			rx_q <= rx_q + cur_q.ix;
			ry_q <= ry_q + cur_q.iy;
			rt_q <= rt_q + cur_q.it;
			k_q <= k_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

// ===== sv/path_waypoint_resampler_top.sv =====
// Path waypoint resampler. Each waypoint after the first closes a segment and
// produces floor(distance/step_length) samples, capped at 64 with clipped set.
// A waypoint holds the input while the front end accepts it, squares the
// offsets, counts samples with one squared compare per cycle (stopping at
// once when an offset is 2^31 or more), divides three times on the shared
// bit-serial divider and hands the segment over once the queue has room; a
// segment with no samples ends after the count, and the first waypoint is
// only stored. The back end emits one sample a cycle, unless out_stall holds
// it, from a two-entry segment queue as the front end takes the next waypoint.
`default_nettype none
module path_waypoint_resampler_top import pwr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [15:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [31:0] pos_x,
	input wire logic signed [31:0] pos_y,
	input wire logic signed [15:0] heading,
	input wire logic signed [15:0] speed,
	input wire logic signed [15:0] steer,
	input wire logic [51:0] time_us,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [15:0] out_heading,
	output logic signed [15:0] out_speed,
	output logic signed [15:0] out_steer,
	output logic [51:0] out_time_us,
	output logic last_of_segment,
	output logic clipped
);
	logic [15:0] step_q;
	logic seg_valid, seg_full;
	seg_t seg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) step_q <= StepReset;
		else if (cfg_we) step_q <= cfg_wdata;
	end

	pwr_front u_front (.clk(clk), .arst_n(arst_n), .step_q(step_q),
		.in_valid(in_valid), .in_stall(in_stall), .px(pos_x), .py(pos_y),
		.phd(heading), .psp(speed), .pst(steer), .pt(time_us),
		.seg_valid(seg_valid), .seg(seg), .seg_full(seg_full));

	pwr_back u_back (.clk(clk), .arst_n(arst_n), .seg_valid(seg_valid), .seg(seg),
		.seg_full(seg_full), .out_valid(out_valid), .out_stall(out_stall),
		.out_x(out_x), .out_y(out_y), .out_heading(out_heading),
		.out_speed(out_speed), .out_steer(out_steer), .out_time_us(out_time_us),
		.last_of_segment(last_of_segment), .clipped(clipped));
endmodule
`default_nettype wire

// ===== sv/pwr_checker.sv =====
// Port-level checks for the resampler, bound to the top level.
// Uses only the top-level ports.
`default_nettype none
module pwr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic signed [31:0] out_x,
	input wire logic last_of_segment
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_x))
		else $error("stalled transaction changed");
	a_last_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(last_of_segment))
		else $error("last flag changed under stall");
	a_no_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(last_of_segment))
		else $error("unknown last flag");
endmodule

bind path_waypoint_resampler_top pwr_checker u_chk (.clk(clk), .arst_n(arst_n),
	.out_valid(out_valid), .out_stall(out_stall), .out_x(out_x),
	.last_of_segment(last_of_segment));
`default_nettype wire
